/* rtl/pfxe_pkg.sv */
// ----------------------------------------------------------------------------
// pfxe_pkg: shared types and helpers for the prefix-exclude codec
// Holds the command codes, the input and result word types, and the
// leading-bit mask function used by the datapath.
// ----------------------------------------------------------------------------
package pfxe_pkg;

    localparam int unsigned PrefixWidth = 128;
    localparam int unsigned HalfWidth   = 64;
    localparam int unsigned LenWidth    = 8;
    localparam int unsigned OctWidth    = 5;

    // Largest delegated length and largest excluded length.
    localparam logic [LenWidth-1:0] MaxDelegatedLen = 8'd127;
    localparam logic [LenWidth-1:0] MaxExcludedLen  = 8'd128;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef logic [PrefixWidth-1:0] prefix_t;

    typedef struct packed {
        logic                command;
        prefix_t             delegated;
        prefix_t             other;
        logic [LenWidth-1:0] deleg_plen;
        logic [LenWidth-1:0] excl_plen;
        logic [LenWidth-1:0] subnet_octets;
    } pfxe_item_t;

    typedef struct packed {
        logic                error;
        prefix_t             value;
        logic [OctWidth-1:0] octets;
    } pfxe_result_t;

    // Mask that keeps the first n bits of a prefix, n in 0..128.
    // A shift by the full width yields zero, which covers n equal to zero.
    function automatic prefix_t lead_mask(input logic [LenWidth-1:0] n);
        logic [LenWidth-1:0] sh;
        sh = MaxExcludedLen - n;
        return ~(prefix_t'(0)) << sh;
    endfunction

endpackage

/* rtl/ipv6_prefix_exclude_codec_core.sv */
// ----------------------------------------------------------------------------
// ipv6_prefix_exclude_codec_core: prefix-exclude subnet ID codec
// Registers each input word, runs the codec datapath and holds the result
// in an output register until the sink takes it.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | sink      | in_valid/in_stall  | command .. subnet_octets
//   out     | source    | out_valid/out_stall| error, result_hi/lo, octets
//
// One word per cycle is sustained while out_stall is low. An accepted word
// enters the input register; its result then moves into the result register,
// when out_valid rises, and waits there until the sink takes it.
// Reset empties both stages; no other state exists.
// The input stalls only while both stages are full and out_stall is high,
// so a new word is taken while a finished result waits at the output.
// ----------------------------------------------------------------------------
module ipv6_prefix_exclude_codec_core
    import pfxe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [HalfWidth-1:0] delegated_hi,
    input  logic [HalfWidth-1:0] delegated_lo,
    input  logic [HalfWidth-1:0] other_hi,
    input  logic [HalfWidth-1:0] other_lo,
    input  logic [LenWidth-1:0] deleg_plen,
    input  logic [LenWidth-1:0] excl_plen,
    input  logic [LenWidth-1:0] subnet_octets,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                error,
    output logic [HalfWidth-1:0] result_hi,
    output logic [HalfWidth-1:0] result_lo,
    output logic [OctWidth-1:0] result_octets
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    pfxe_item_t   item_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    pfxe_result_t result_reg;
    pfxe_result_t result_next;
    logic         out_hold;
    logic         in_take;

    assign out_hold = out_valid_reg && out_stall;
    assign in_stall = s1_valid_reg && out_hold;
    assign in_take  = in_valid && !in_stall;

    pfxe_datapath u_datapath
    (
        .item   (item_reg),
        .result (result_next)
    );

    always_comb
    begin
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        out_valid_next = out_hold ? out_valid_reg : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= '{command:       command,
                          delegated:     {delegated_hi, delegated_lo},
                          other:         {other_hi, other_lo},
                          deleg_plen:    deleg_plen,
                          excl_plen:     excl_plen,
                          subnet_octets: subnet_octets};
        end
        if (!out_hold && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign error         = result_reg.error;
    assign result_hi     = result_reg.value[PrefixWidth-1:HalfWidth];
    assign result_lo     = result_reg.value[HalfWidth-1:0];
    assign result_octets = result_reg.octets;

    // A failed check never leaks partial data.
    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.error |->
            result_reg.value == '0 && result_reg.octets == '0)
        else $error("error word carries nonzero result");

    // A good word has an octet count of at most sixteen.
    a_octets_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.error |-> result_reg.octets <= 5'd16)
        else $error("octet count out of range");

    // Backpressure reaches the input only when both stages hold a word.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with an empty stage");

    // A taken result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !s1_valid_reg |=> !out_valid_reg)
        else $error("result repeated after it was taken");

endmodule

/* rtl/pfxe_datapath.sv */
// ----------------------------------------------------------------------------
// pfxe_datapath: length checks, prefix compare and subnet ID shift
// Pure combinational logic that turns one registered input word into one
// result word, for both the encode and the decode direction.
// ----------------------------------------------------------------------------
module pfxe_datapath
    import pfxe_pkg::*;
(
    input  pfxe_item_t   item,
    output pfxe_result_t result
);

    logic                bad_len;
    logic [LenWidth-1:0] span;
    logic [LenWidth-1:0] span_m1;
    logic [OctWidth-1:0] octets;
    logic [6:0]          shift;
    prefix_t             lead_a;
    prefix_t             lead_span;
    logic                mismatch;
    logic                bad_octets;
    prefix_t             enc_value;
    prefix_t             dec_value;

    always_comb
    begin
        bad_len = (item.deleg_plen > MaxDelegatedLen) ||
                  (item.excl_plen <= item.deleg_plen) ||
                  (item.excl_plen > MaxExcludedLen);
        span    = item.excl_plen - item.deleg_plen;
        span_m1 = span - 8'd1;
        octets  = OctWidth'(span_m1[6:3]) + 5'd1;
        // Only meaningful when the lengths pass, so a fits in seven bits.
        shift     = item.deleg_plen[6:0];
        lead_a    = lead_mask(item.deleg_plen);
        lead_span = lead_mask(span);

        mismatch   = |((item.delegated ^ item.other) & lead_a);
        bad_octets = (item.subnet_octets != LenWidth'(octets));

        enc_value = (item.other << shift) & lead_span;
        dec_value = (item.delegated & lead_a) | ((item.other & lead_span) >> shift);

        result = '{error: 1'b1, value: '0, octets: '0};
        if (!bad_len)
        begin
            case (item.command)
                CMD_ENCODE:
                begin
                    if (!mismatch)
                    begin
                        result = '{error: 1'b0, value: enc_value, octets: octets};
                    end
                end
                CMD_DECODE:
                begin
                    if (!bad_octets)
                    begin
                        result = '{error: 1'b0, value: dec_value, octets: '0};
                    end
                end
                default:
                begin
                    result = '{error: 1'b1, value: '0, octets: '0};
                end
            endcase
        end
    end

endmodule

/* bench/ipv6_prefix_exclude_codec_checker.sv */
// ----------------------------------------------------------------------------
// ipv6_prefix_exclude_codec_checker: result predictor and scoreboard
// Watches both channels of the prefix-exclude codec. Every word accepted on
// the input side is turned into its expected result and queued. Every word
// accepted on the output side is compared field by field with the oldest
// queued expectation.
// ----------------------------------------------------------------------------
module ipv6_prefix_exclude_codec_checker
    import pfxe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 command,
    input  logic [HalfWidth-1:0] delegated_hi,
    input  logic [HalfWidth-1:0] delegated_lo,
    input  logic [HalfWidth-1:0] other_hi,
    input  logic [HalfWidth-1:0] other_lo,
    input  logic [LenWidth-1:0]  deleg_plen,
    input  logic [LenWidth-1:0]  excl_plen,
    input  logic [LenWidth-1:0]  subnet_octets,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 error,
    input  logic [HalfWidth-1:0] result_hi,
    input  logic [HalfWidth-1:0] result_lo,
    input  logic [OctWidth-1:0]  result_octets,
    output int                   fail_count,
    output int                   pending
);

    pfxe_result_t owed_results[$];
    pfxe_result_t want;
    int           mismatches;

    function automatic prefix_t first_bits(input int n);
        if (n <= 0)
            return '0;
        return ~prefix_t'(0) << (PrefixWidth - n);
    endfunction

    function automatic pfxe_result_t codec_predict(input logic cmd, input prefix_t dlg,
                                                   input prefix_t oth, input int a,
                                                   input int b, input int oct_in);
        pfxe_result_t r;
        int           octets;
        r.error  = 1'b1;
        r.value  = '0;
        r.octets = '0;
        if (a > MaxDelegatedLen || b <= a || b > MaxExcludedLen)
            return r;
        octets = (b - a - 1) / 8 + 1;
        if (cmd == CMD_ENCODE)
        begin
            // Both prefixes must agree on every delegated bit.
            if (((dlg ^ oth) & first_bits(a)) != '0)
                return r;
            r.value  = (oth << a) & first_bits(b - a);
            r.octets = OctWidth'(octets);
        end
        else
        begin
            if (oct_in != octets)
                return r;
            // Subnet bits past b-a are dropped before they are moved into place.
            r.value = (dlg & first_bits(a)) | ((oth & first_bits(b - a)) >> a);
        end
        r.error = 1'b0;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [HalfWidth-1:0] exp_val,
                                 input logic [HalfWidth-1:0] act_val);
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, exp_val, act_val);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result word with no expectation: error=%0b hi=%h lo=%h oct=%0d",
                             $time, error, result_hi, result_lo, result_octets);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (error !== want.error)
                        note_mismatch("error", HalfWidth'(want.error), HalfWidth'(error));
                    if (result_hi !== want.value[PrefixWidth-1:HalfWidth])
                        note_mismatch("result_hi", want.value[PrefixWidth-1:HalfWidth], result_hi);
                    if (result_lo !== want.value[HalfWidth-1:0])
                        note_mismatch("result_lo", want.value[HalfWidth-1:0], result_lo);
                    if (result_octets !== want.octets)
                        note_mismatch("result_octets", HalfWidth'(want.octets),
                                      HalfWidth'(result_octets));
                end
            end
            if (in_valid && !in_stall)
                owed_results.push_back(codec_predict(command, {delegated_hi, delegated_lo},
                                                     {other_hi, other_lo}, int'(deleg_plen),
                                                     int'(excl_plen), int'(subnet_octets)));
        end
        fail_count <= mismatches;
        pending    <= owed_results.size();
    end

endmodule

/* bench/ipv6_prefix_exclude_codec_core_tb.sv */
// ----------------------------------------------------------------------------
// ipv6_prefix_exclude_codec_core_tb: testbench for the prefix-exclude codec
// Drives a directed set of encode and decode words covering length limits,
// prefix mismatches and octet count errors, then a long random run of mostly
// well-formed words with random gaps and output stalls. A checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ipv6_prefix_exclude_codec_core_tb;
    import pfxe_pkg::*;

    localparam int QuietLimit   = 2000;
    localparam int RandomWords  = 850;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic [HalfWidth-1:0] delegated_hi;
    logic [HalfWidth-1:0] delegated_lo;
    logic [HalfWidth-1:0] other_hi;
    logic [HalfWidth-1:0] other_lo;
    logic [LenWidth-1:0]  deleg_plen;
    logic [LenWidth-1:0]  excl_plen;
    logic [LenWidth-1:0]  subnet_octets;
    logic                 out_valid;
    logic                 out_stall;
    logic                 error;
    logic [HalfWidth-1:0] result_hi;
    logic [HalfWidth-1:0] result_lo;
    logic [OctWidth-1:0]  result_octets;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles;
    int                   send_calm;
    int                   take_calm;

    ipv6_prefix_exclude_codec_core u_top (.*);

    ipv6_prefix_exclude_codec_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Wait length for one word; now and then a run of words goes with no wait.
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(10, 40);
            gap  = 0;
        end
        else
        begin
            gap = $urandom_range(0, 15);
        end
    endtask

    function automatic logic [HalfWidth-1:0] rand_half();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic cmd, input prefix_t dlg, input prefix_t oth,
                             input int a, input int b, input int oct);
        int gap;
        draw_gap(send_calm, gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command       <= cmd;
        delegated_hi  <= dlg[PrefixWidth-1:HalfWidth];
        delegated_lo  <= dlg[HalfWidth-1:0];
        other_hi      <= oth[PrefixWidth-1:HalfWidth];
        other_lo      <= oth[HalfWidth-1:0];
        deleg_plen    <= LenWidth'(a);
        excl_plen     <= LenWidth'(b);
        subnet_octets <= LenWidth'(oct);
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random();
        prefix_t dlg;
        prefix_t oth;
        prefix_t keep;
        logic    cmd;
        int      a;
        int      b;
        int      oct;
        dlg = {rand_half(), rand_half()};
        oth = {rand_half(), rand_half()};
        cmd = $urandom_range(0, 1) ? CMD_DECODE : CMD_ENCODE;
        if ($urandom_range(0, 99) < 12)
        begin
            // Noise: raw length bytes, mostly out of range.
            a   = $urandom_range(0, 255);
            b   = $urandom_range(0, 255);
            oct = $urandom_range(0, 255);
        end
        else
        begin
            case ($urandom_range(0, 7))
                0:       a = 0;
                1:       a = MaxDelegatedLen;
                2:       a = 64;
                3:       a = $urandom_range(0, 16) * 8;
                default: a = $urandom_range(0, MaxDelegatedLen);
            endcase
            case ($urandom_range(0, 5))
                0:       b = MaxExcludedLen;
                1:       b = a + 1;
                default: b = $urandom_range(a + 1, MaxExcludedLen);
            endcase
            oct = (b - a - 1) / 8 + 1;
            if (cmd == CMD_DECODE && $urandom_range(0, 99) < 15)
                oct = $urandom_range(0, 255);
            else if (cmd == CMD_ENCODE && $urandom_range(0, 3) == 0)
                oct = $urandom_range(0, 255);
            // Most encode words share the delegated bits so they get past the check.
            keep = ~prefix_t'(0) << (PrefixWidth - a);
            if (cmd == CMD_ENCODE && $urandom_range(0, 99) < 88)
                oth = (dlg & keep) | (oth & ~keep);
        end
        send_word(cmd, dlg, oth, a, b, oct);
    endtask

    // Output side: raise out_stall for a random gap, at times none, before each result.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        take_calm = 0;
        wait (rst_n);
        forever
        begin
            draw_gap(take_calm, gap);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid || out_stall);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        prefix_t p1;
        prefix_t p2;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_ENCODE;
        delegated_hi  = '0;
        delegated_lo  = '0;
        other_hi      = '0;
        other_lo      = '0;
        deleg_plen    = '0;
        excl_plen     = '0;
        subnet_octets = '0;
        send_calm     = 0;
        p1 = 128'h2001_0db8_1234_5678_9abc_def0_1122_3344;
        p2 = 128'hfedc_ba98_7654_3210_0f1e_2d3c_4b5a_6978;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encode: full-width, single-bit and byte-sized subnet IDs, and prefix mismatches.
        send_word(CMD_ENCODE, '0, '1, 0, 128, 0);
        send_word(CMD_ENCODE, '1, '1, 127, 128, 0);
        send_word(CMD_ENCODE, p1, {p1[127:64], p2[63:0]}, 64, 72, 0);
        send_word(CMD_ENCODE, p1, {p1[127:0]} ^ {1'b1, 127'b0}, 56, 64, 0);
        send_word(CMD_ENCODE, p2, p2 ^ 128'h2, 127, 128, 0);
        send_word(CMD_ENCODE, p1, p1, 32, 48, 255);
        send_word(CMD_ENCODE, p2, {p2[127:65], 1'b0, 64'h0}, 63, 128, 7);
        // Encode with bad lengths.
        send_word(CMD_ENCODE, p1, p1, 128, 128, 0);
        send_word(CMD_ENCODE, p1, p1, 10, 10, 0);
        send_word(CMD_ENCODE, p1, p1, 0, 129, 0);
        send_word(CMD_ENCODE, '1, '1, 255, 255, 255);
        // Decode: extremes of both lengths, junk past the subnet bits.
        send_word(CMD_DECODE, '0, '1, 0, 128, 16);
        send_word(CMD_DECODE, '1, '1, 127, 128, 1);
        send_word(CMD_DECODE, p1, p2, 48, 64, 2);
        send_word(CMD_DECODE, p2, '1, 64, 65, 1);
        send_word(CMD_DECODE, p1, '0, 5, 128, 16);
        // Decode with a wrong octet count or bad lengths.
        send_word(CMD_DECODE, p1, p2, 48, 64, 3);
        send_word(CMD_DECODE, p1, p2, 48, 64, 255);
        send_word(CMD_DECODE, p1, p2, 48, 64, 0);
        send_word(CMD_DECODE, p1, p2, 0, 0, 0);
        send_word(CMD_DECODE, p2, p1, 127, 255, 1);
        send_word(CMD_DECODE, p2, p1, 128, 129, 1);

        drain_results();

        for (int i = 0; i < RandomWords; i++)
        begin
            send_random();
            if (i == RandomWords / 2)
                drain_results();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
